// ===== design/ssed_pkg.sv =====
// ----------------------------------------------------------------------------
// ssed_pkg
// Shared constants for the scale-space extremum detector: configuration
// register indexes, register reset values, fixed field widths and clamp limits.
// ----------------------------------------------------------------------------
package ssed_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned DimW     = 13;
  localparam int unsigned LimitW   = 15;
  localparam int unsigned PosW     = 12;
  localparam int unsigned RespW    = 16;

  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_CONTRAST_LIMIT = 2'd2;

  localparam logic [DimW-1:0]   WIDTH_RESET  = 13'd640;
  localparam logic [DimW-1:0]   HEIGHT_RESET = 13'd480;
  localparam logic [LimitW-1:0] LIMIT_RESET  = 15'd0;

  localparam logic [DimW-1:0]  DIM_MIN    = 13'd3;
  localparam logic [DimW-1:0]  HEIGHT_MAX = 13'd4096;
  localparam logic [RespW-1:0] RESP_MAX   = 16'hFFFF;

endpackage

// ===== design/scale_space_extremum_detector_top.sv =====
// ----------------------------------------------------------------------------
// scale_space_extremum_detector_top
// 3x3x3 extremum test over three difference-of-Gaussian layers, streamed in
// raster order, with a two-row line memory and a 27-sample window.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Beat contents
//   in       sink       in_valid_i / in_stall_o   three samples, frame_start
//   out      source     out_valid_o / out_stall_i column, row, is_maximum,
//                                                 response
//   cfg      sink       cfg_valid_i / cfg_ready_o register index, data
//
// One input beat is taken every cycle unless the output stalls. The line memory
// serves one read and one write per cycle, and a read that meets the previous
// beat's write is forwarded. Results go through s1 and s2 to the output register.
// Reset clears counters, window and pipeline valids; the line memory has no
// reset and needs no clearing pass. A stalled output beat freezes the pipeline.
// ----------------------------------------------------------------------------
module scale_space_extremum_detector_top #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_below_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_middle_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_above_i,
  input  logic                                 frame_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ssed_pkg::PosW-1:0]            point_column_o,
  output logic [ssed_pkg::PosW-1:0]            point_row_o,
  output logic                                 is_maximum_o,
  output logic [ssed_pkg::RespW-1:0]           response_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ssed_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ssed_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned CNTW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW   = (CNTW > ssed_pkg::DimW) ? CNTW : ssed_pkg::DimW;
  localparam int unsigned MW   = (SB > ssed_pkg::RespW) ? SB : ssed_pkg::RespW;
  localparam int unsigned RW   = ssed_pkg::DimW;

  // Configuration registers.
  logic [ssed_pkg::DimW-1:0]   width_q, height_q;
  logic [ssed_pkg::LimitW-1:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ssed_pkg::WIDTH_RESET;
      height_q <= ssed_pkg::HEIGHT_RESET;
      limit_q  <= ssed_pkg::LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ssed_pkg::REG_IMAGE_WIDTH:    width_q  <= cfg_data_i[ssed_pkg::DimW-1:0];
        ssed_pkg::REG_IMAGE_HEIGHT:   height_q <= cfg_data_i[ssed_pkg::DimW-1:0];
        ssed_pkg::REG_CONTRAST_LIMIT: limit_q  <= cfg_data_i[ssed_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic en, in_acc;
  logic out_valid_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && en;

  // Position counters.
  logic [CNTW-1:0] col_q, col_base, col_nx;
  logic [RW-1:0]   row_q, row_base, row_nx;
  logic [WW-1:0]   w_eff;
  logic [RW-1:0]   h_eff;
  logic [CW-1:0]   c_in;
  logic            test_in;

  always_comb begin
    if (width_q < ssed_pkg::DIM_MIN) begin
      w_eff = WW'(ssed_pkg::DIM_MIN);
    end else if (WW'(width_q) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q < ssed_pkg::DIM_MIN) begin
      h_eff = ssed_pkg::DIM_MIN;
    end else if (height_q > ssed_pkg::HEIGHT_MAX) begin
      h_eff = ssed_pkg::HEIGHT_MAX;
    end else begin
      h_eff = height_q;
    end
    col_base = frame_start_i ? '0 : col_q;
    row_base = frame_start_i ? '0 : row_q;
    if (WW'(col_base) >= w_eff) begin
      col_nx = '0;
      row_nx = row_base + 1'b1;
    end else begin
      col_nx = col_base;
      row_nx = row_base;
    end
    if (row_nx >= h_eff) begin
      row_nx = '0;
    end
    c_in    = col_nx[CW-1:0];
    test_in = (col_nx >= CNTW'(2)) && (row_nx >= RW'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_nx + 1'b1;
      row_q <= row_nx;
    end
  end

  // Line memory: words 0..2 hold the older row, words 3..5 the newer row.
  logic [5:0][SB-1:0] mem_q [MAX_WIDTH];
  logic [5:0][SB-1:0] rd_q, fwd_q, eff;
  logic [2:0][SB-1:0] fresh_in, s1_fresh_q;

  logic                    s1_valid_q, s1_fwd_q, s1_test_q;
  logic [CW-1:0]           s1_col_q;
  logic [ssed_pkg::PosW-1:0] s1_row_q;

  assign fresh_in = {sample_above_i, sample_middle_i, sample_below_i};
  assign eff      = s1_fwd_q ? fwd_q : rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= mem_q[c_in];
    end
    if (en && s1_valid_q) begin
      mem_q[s1_col_q] <= {s1_fresh_q, eff[5:3]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_fresh_q <= fresh_in;
      s1_col_q   <= c_in;
      s1_row_q   <= row_nx[ssed_pkg::PosW-1:0];
      s1_test_q  <= test_in;
      fwd_q      <= {s1_fresh_q, eff[5:3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_fwd_q   <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_acc;
      if (in_acc) begin
        s1_fwd_q <= s1_valid_q && (c_in == s1_col_q);
      end
    end
  end

  // Window: [layer][row][column], column 2 newest.
  logic signed [SB-1:0] win_q [3][3][3];
  logic                 s2_valid_q, s2_test_q;
  logic [CW-1:0]        s2_col_q;
  logic [ssed_pkg::PosW-1:0] s2_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < 3; l++) begin
        for (int y = 0; y < 3; y++) begin
          for (int x = 0; x < 3; x++) begin
            win_q[l][y][x] <= '0;
          end
        end
      end
    end else if (en && s1_valid_q) begin
      for (int l = 0; l < 3; l++) begin
        for (int y = 0; y < 3; y++) begin
          win_q[l][y][0] <= win_q[l][y][1];
          win_q[l][y][1] <= win_q[l][y][2];
        end
        win_q[l][0][2] <= eff[l];
        win_q[l][1][2] <= eff[3+l];
        win_q[l][2][2] <= s1_fresh_q[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_valid_q) begin
      s2_test_q <= s1_test_q;
      s2_col_q  <= s1_col_q;
      s2_row_q  <= s1_row_q;
    end
  end

  // Extremum test.
  logic signed [SB-1:0] center;
  logic                 is_max, is_min, hit;
  logic [SB-1:0]        mag;
  logic [MW-1:0]        mag_w;

  always_comb begin
    center = win_q[1][1][1];
    is_max = 1'b1;
    is_min = 1'b1;
    for (int l = 0; l < 3; l++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          if (!(l == 1 && y == 1 && x == 1)) begin
            if (win_q[l][y][x] >= center) is_max = 1'b0;
            if (win_q[l][y][x] <= center) is_min = 1'b0;
          end
        end
      end
    end
    mag   = center[SB-1] ? (~center + 1'b1) : center;
    mag_w = MW'(mag);
    hit   = s2_valid_q && s2_test_q && (is_max || is_min) && (mag_w >= MW'(limit_q));
  end

  // Output register.
  logic [ssed_pkg::PosW-1:0]  out_col_q, out_row_q;
  logic                       out_max_q;
  logic [ssed_pkg::RespW-1:0] out_resp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_col_q  <= ssed_pkg::PosW'(s2_col_q - 1'b1);
      out_row_q  <= s2_row_q - 1'b1;
      out_max_q  <= is_max;
      out_resp_q <= (mag_w > MW'(ssed_pkg::RESP_MAX)) ? ssed_pkg::RESP_MAX
                                                      : mag_w[ssed_pkg::RespW-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign point_column_o = out_col_q;
  assign point_row_o    = out_row_q;
  assign is_maximum_o   = out_max_q;
  assign response_o     = out_resp_q;

endmodule

// ===== design/ssed_checker.sv =====
// ----------------------------------------------------------------------------
// ssed_checker
// Port-level checks for the scale-space extremum detector, bound to the top.
// ----------------------------------------------------------------------------
module ssed_checker #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [SAMPLE_BITS-1:0]        sample_below_i,
  input logic [SAMPLE_BITS-1:0]        sample_middle_i,
  input logic [SAMPLE_BITS-1:0]        sample_above_i,
  input logic                          frame_start_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [ssed_pkg::PosW-1:0]     point_column_o,
  input logic [ssed_pkg::PosW-1:0]     point_row_o,
  input logic                          is_maximum_o,
  input logic [ssed_pkg::RespW-1:0]    response_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [ssed_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [ssed_pkg::CfgDataW-1:0] cfg_data_i
);

  // A stalled result beat stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(point_column_o)
      && $stable(point_row_o) && $stable(is_maximum_o) && $stable(response_o))
    else $error("stalled result beat changed");

  // The input side backs up only behind a held result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // Reported rows lie strictly inside the largest frame, from 1 to 4094.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> point_row_o != '0 && point_row_o <= 12'd4094)
    else $error("result row on the frame border");

  // Configuration writes are never refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration beat refused");

endmodule

bind scale_space_extremum_detector_top ssed_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_ssed_checker (.*);
